[rtl/positional_list_engine_top_assert.svh]
// assertion macros for the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/ple_pkg.sv]
// shared types, constants and helpers of the positional list engine
package ple_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef logic signed [31:0] data_t;

  typedef enum logic [2:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DISPLAY   = 3'd6,
    CMD_COUNT     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;
  } cell_ctl_t;

  // count or index masked to the 6-bit result fields
  function automatic logic [5:0] to_six(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(cnt);
    return wide[5:0];
  endfunction

endpackage

[rtl/ple_in_if.sv]
// command channel of the positional list engine
interface ple_in_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               command;
  logic signed [31:0] value_in;
  logic [5:0]         position;

  modport source (output valid, command, value_in, position, input ready);
  modport sink   (input valid, command, value_in, position, output ready);
endinterface

[rtl/ple_out_if.sv]
// result channel of the positional list engine
interface ple_out_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic [5:0]         entry_index;
  logic [5:0]         entry_count;
  status_t            status;
  logic               last;

  modport source (output valid, value_out, entry_index, entry_count, status, last,
                  input ready);
  modport sink   (input valid, value_out, entry_index, entry_count, status, last,
                  output ready);
endinterface

[rtl/ple_cell.sv]
// one list slot: holds an entry and shifts or rotates with its neighbors
module ple_cell (
  input  logic                          clk,
  input  ple_pkg::cell_ctl_t            ctl,
  input  logic [ple_pkg::IDX_W-1:0]     idx,
  input  ple_pkg::data_t                left_d,
  input  ple_pkg::data_t                right_d,
  input  ple_pkg::data_t                head_d,
  input  ple_pkg::data_t                ins_d,
  output ple_pkg::data_t                data_q
);
  import ple_pkg::*;

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      OP_HOLD: data_nxt = data_r;
      OP_INS: begin
        if (idx > ctl.pos) begin
          data_nxt = left_d;
        end else if (idx == ctl.pos) begin
          data_nxt = ins_d;
        end
      end
      OP_DEL: begin
        if (idx >= ctl.pos) begin
          data_nxt = right_d;
        end
      end
      OP_ROT: begin
        // pos marks the tail; the head entry wraps around to it
        if (idx < ctl.pos) begin
          data_nxt = right_d;
        end else if (idx == ctl.pos) begin
          data_nxt = head_d;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[rtl/ple_ctrl.sv]
// command decode, size count, display sequencing and result register
module ple_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  ple_in_if.sink             in_ch,
  ple_out_if.source          out_ch,
  output ple_pkg::cell_ctl_t ctl,
  output ple_pkg::data_t     ins_d,
  input  ple_pkg::data_t     head_d
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0] disp_cnt_r, disp_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_value_r, out_value_nxt;
  logic [5:0]       out_index_r, out_index_nxt;
  logic [5:0]       out_count_r, out_count_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic             in_xfer;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] size_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [CNT_W-1:0] size_m1;
  logic [CNT_W-1:0] disp_cnt_p1;
  logic             ins_ok;
  status_t          st;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && (state_r == S_IDLE) && slot_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pos_ext     = CMP_W'(in_ch.position);
  assign size_ext    = CMP_W'(size_r);
  assign pos_m1      = pos_ext - CMP_W'(1);
  assign size_m1     = size_r - CNT_W'(1);
  assign disp_cnt_p1 = disp_cnt_r + CNT_W'(1);
  assign ins_d       = in_ch.value_in;
  assign ins_ok      = (in_ch.command == CMD_INS_FIRST) || (in_ch.command == CMD_INS_LAST)
                    || (in_ch.command == CMD_INS_AT);

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    disp_cnt_nxt   = disp_cnt_r;
    ctl.op         = OP_HOLD;
    ctl.pos        = '0;
    st             = ST_OK;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.command)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
              if (size_r == CNT_W'(DEPTH)) begin
                st = ST_FULL;
              end else if (in_ch.command == CMD_INS_AT &&
                           (pos_ext == '0 || pos_ext > size_ext + CMP_W'(1))) begin
                st = ST_BADPOS;
              end else begin
                ctl.op   = OP_INS;
                size_nxt = size_r + CNT_W'(1);
                if (in_ch.command == CMD_INS_FIRST) begin
                  ctl.pos = '0;
                end else if (in_ch.command == CMD_INS_LAST) begin
                  ctl.pos = size_r[IDX_W-1:0];
                end else begin
                  ctl.pos = pos_m1[IDX_W-1:0];
                end
              end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
              if (size_r == '0) begin
                st = ST_EMPTY;
              end else if (in_ch.command == CMD_DEL_AT &&
                           (pos_ext == '0 || pos_ext > size_ext)) begin
                st = ST_BADPOS;
              end else begin
                ctl.op   = OP_DEL;
                size_nxt = size_m1;
                if (in_ch.command == CMD_DEL_FIRST) begin
                  ctl.pos = '0;
                end else if (in_ch.command == CMD_DEL_LAST) begin
                  ctl.pos = size_m1[IDX_W-1:0];
                end else begin
                  ctl.pos = pos_m1[IDX_W-1:0];
                end
              end
            end
            CMD_DISPLAY: begin
              if (size_r == '0) begin
                st = ST_EMPTY;
              end
            end
            CMD_COUNT: st = ST_OK;
          endcase

          if (in_ch.command == CMD_DISPLAY && size_r != '0) begin
            state_nxt    = S_DISP;
            disp_cnt_nxt = '0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_index_nxt  = '0;
            out_count_nxt  = to_six(size_nxt);
            out_status_nxt = st;
            out_last_nxt   = 1'b1;
          end
        end
      end
      S_DISP: begin
        if (slot_free) begin
          // head leaves the chain each step and comes back at the tail
          ctl.op         = OP_ROT;
          ctl.pos        = size_m1[IDX_W-1:0];
          out_valid_nxt  = 1'b1;
          out_value_nxt  = head_d;
          out_index_nxt  = to_six(disp_cnt_p1);
          out_count_nxt  = to_six(size_r);
          out_status_nxt = ST_OK;
          out_last_nxt   = (disp_cnt_p1 == size_r);
          disp_cnt_nxt   = disp_cnt_p1;
          if (disp_cnt_p1 == size_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      disp_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      disp_cnt_r  <= disp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;

`include "positional_list_engine_top_assert.svh"

  `PLE_ASSERT(a_size_bound, size_r <= CNT_W'(DEPTH), "list size above depth")
  `PLE_ASSERT(a_disp_cnt, (state_r != S_DISP) || (disp_cnt_r < size_r), "display past tail")
  `PLE_ASSERT(a_nonlast_in_disp, !(out_valid_r && !out_last_r) || (state_r == S_DISP), "non-final result outside display")
  `PLE_ASSERT_NEXT(a_ins_grows, in_xfer && ins_ok && (in_ch.command != CMD_INS_AT) && (size_r < CNT_W'(DEPTH)), size_r == $past(size_r) + CNT_W'(1), "insert did not grow list")

endmodule

[rtl/positional_list_engine_top.sv]
// top level of the positional list engine: controller and chain of list cells
// Holds an ordered list of up to DEPTH signed 32-bit entries, one entry per cell
// of a shift chain. Every command except display completes as it is taken: inserts
// and deletes shift all cells at once and the single result is registered for
// the next cycle, so back-to-back commands run at one per cycle while the result
// side keeps up. A display of a list of size N holds the command channel until it
// has given its N results, one per cycle, each step rotating the chain by one cell
// so the head entry feeds the result register; output stalls stretch it further.
// Results of every command are in order; last marks the final one. No clearing
// pass after reset: only slots below the count are ever shown.
module positional_list_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  ple_in_if.sink     in_ch,
  ple_out_if.source  out_ch
);
  import ple_pkg::*;

  cell_ctl_t ctl;
  data_t     ins_d;
  data_t     cell_q [DEPTH];

  ple_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctl    (ctl),
    .ins_d  (ins_d),
    .head_d (cell_q[0])
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t left_d;
    data_t right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    ple_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (IDX_W'(g)),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .ins_d   (ins_d),
      .data_q  (cell_q[g])
    );
  end

endmodule

[verif/ple_result_checker.sv]
// result checker of the positional list engine: behavioral list, expected results, compare
module ple_result_checker
  import ple_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ple_in_if    cmd_mon,
  ple_out_if   res_mon,
  output int   mismatch_count,
  output int   results_owed
);

  typedef struct packed {
    data_t      value;
    logic [5:0] index;
    logic [5:0] count;
    status_t    status;
    logic       last;
  } list_result_t;

  data_t        list_mem [DEPTH];
  int           list_len = 0;
  list_result_t expected_results [$];
  int           err_total = 0;

  function automatic list_result_t make_result(data_t v, int idx, status_t st, logic fin);
    list_result_t r;
    r.value  = v;
    r.index  = 6'(idx);
    r.count  = 6'(list_len);
    r.status = st;
    r.last   = fin;
    return r;
  endfunction

  // update the behavioral list and queue the results one command causes
  task automatic apply_command(cmd_t cmd, data_t val, logic [5:0] pos);
    status_t st;
    int      slot;
    int      i;
    st   = ST_OK;
    slot = -1;
    case (cmd)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else if (cmd == CMD_INS_FIRST) slot = 0;
        else if (cmd == CMD_INS_LAST) slot = list_len;
        else if (int'(pos) < 1 || int'(pos) > list_len + 1) st = ST_BADPOS;
        else slot = int'(pos) - 1;
        if (slot >= 0) begin
          for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = val;
          list_len++;
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (cmd == CMD_DEL_FIRST) slot = 0;
        else if (cmd == CMD_DEL_LAST) slot = list_len - 1;
        else if (int'(pos) < 1 || int'(pos) > list_len) st = ST_BADPOS;
        else slot = int'(pos) - 1;
        if (slot >= 0) begin
          for (i = slot; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_DISPLAY: begin
        if (list_len == 0) expected_results.push_back(make_result('0, 0, ST_EMPTY, 1'b1));
        for (i = 0; i < list_len; i++)
          expected_results.push_back(make_result(list_mem[i], i + 1, ST_OK,
                                                 i == list_len - 1));
      end
      default: ;
    endcase
    if (cmd != CMD_DISPLAY) expected_results.push_back(make_result('0, 0, st, 1'b1));
  endtask

  task automatic compare_field(string fname, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        apply_command(cmd_mon.command, cmd_mon.value_in, cmd_mon.position);
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: value_out %0d, status %0d",
                 res_mon.value_out, res_mon.status);
          err_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("value_out", longint'(want.value), longint'(res_mon.value_out));
          compare_field("entry_index", longint'(want.index), longint'(res_mon.entry_index));
          compare_field("entry_count", longint'(want.count), longint'(res_mon.entry_count));
          compare_field("status", longint'(want.status), longint'(res_mon.status));
          compare_field("last", longint'(want.last), longint'(res_mon.last));
        end
      end
    end
    mismatch_count <= err_total;
    results_owed   <= expected_results.size();
  end

endmodule

[verif/tb_top.sv]
// testbench top of the positional list engine: clock, reset, command traffic and verdict
module tb_top;
  import ple_pkg::*;

  localparam int HOLD_LEN     = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  logic        clk;
  logic        rst_n;
  int          mismatch_count;
  int          results_owed;
  idle_phase_t idle_phase = PH_STEADY;
  bit          hold_req = 1'b0;
  int          list_len_est = 0;
  int          cycle_cnt = 0;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ple_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_mon        (in_ch),
    .res_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls per phase, plus one long hold-off on request
  initial begin
    int stall_pct;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        stall_pct = (idle_phase == PH_RECV_STALL) ? 88 : (idle_phase == PH_BOTH) ? 18 : 0;
        out_ch.ready <= !($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_command(cmd_t cmd, data_t val, logic [5:0] pos);
    int gap_pct;
    gap_pct = (idle_phase == PH_SEND_IDLE) ? 88 : (idle_phase == PH_BOTH) ? 18 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.value_in <= val;
    in_ch.position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // rough list size, only to steer positions toward legal ones
    case (cmd)
      CMD_INS_FIRST, CMD_INS_LAST: if (list_len_est < DEPTH) list_len_est++;
      CMD_INS_AT:
        if (list_len_est < DEPTH && pos >= 1 && int'(pos) <= list_len_est + 1) list_len_est++;
      CMD_DEL_FIRST, CMD_DEL_LAST: if (list_len_est > 0) list_len_est--;
      CMD_DEL_AT: if (pos >= 1 && int'(pos) <= list_len_est) list_len_est--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic run_random(int n, int ins_pct, int del_pct, int hold_at);
    int         k;
    int         roll;
    int         kind;
    cmd_t       cmd;
    data_t      val;
    logic [5:0] pos;
    for (k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      roll = $urandom_range(99);
      kind = $urandom_range(2);
      if (roll < ins_pct)
        cmd = cmd_t'((kind == 0) ? CMD_INS_FIRST : (kind == 1) ? CMD_INS_LAST : CMD_INS_AT);
      else if (roll < ins_pct + del_pct)
        cmd = cmd_t'((kind == 0) ? CMD_DEL_FIRST : (kind == 1) ? CMD_DEL_LAST : CMD_DEL_AT);
      else
        cmd = cmd_t'(($urandom_range(2) == 0) ? CMD_COUNT : CMD_DISPLAY);
      val = data_t'($urandom);
      if ($urandom_range(9) == 0) val = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      if ($urandom_range(99) < 15)
        pos = 6'($urandom_range(63));
      else if (cmd == CMD_DEL_AT)
        pos = 6'($urandom_range((list_len_est > 0) ? list_len_est : 1, 1));
      else
        pos = 6'($urandom_range(list_len_est + 1, 1));
      send_command(cmd, val, pos);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_COUNT;
    in_ch.value_in <= '0;
    in_ch.position <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: display, count and every delete
    send_command(CMD_DISPLAY, '0, '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_DEL_FIRST, '0, '0);
    send_command(CMD_DEL_LAST, '0, '0);
    send_command(CMD_DEL_AT, '0, 6'd0);
    send_command(CMD_DEL_AT, '0, 6'd63);
    // insert positions at and past the edges
    send_command(CMD_INS_AT, 32'sd5, 6'd0);
    send_command(CMD_INS_AT, 32'sd6, 6'd2);
    send_command(CMD_INS_AT, 32'sh7FFF_FFFF, 6'd1);
    send_command(CMD_INS_FIRST, 32'sh8000_0000, '0);
    send_command(CMD_INS_LAST, -32'sd1, '0);
    send_command(CMD_INS_AT, 32'sd0, 6'd4);
    send_command(CMD_INS_AT, 32'sd7, 6'd6);
    send_command(CMD_INS_AT, 32'sd8, 6'd63);
    send_command(CMD_INS_AT, 32'sh5555_5555, 6'd2);
    send_command(CMD_DISPLAY, '0, '0);
    // delete positions at and past the edges
    send_command(CMD_DEL_AT, '0, 6'd0);
    send_command(CMD_DEL_AT, '0, 6'd6);
    send_command(CMD_DEL_AT, '0, 6'd5);
    send_command(CMD_DEL_AT, '0, 6'd2);
    send_command(CMD_DEL_FIRST, '0, '0);
    send_command(CMD_DEL_LAST, '0, '0);
    send_command(CMD_COUNT, '0, '0);
    send_command(CMD_DISPLAY, '0, '0);

    // fill toward full, with a long result hold-off while commands keep coming
    run_random(30, 85, 5, 10);
    wait_drained();
    idle_phase = PH_SEND_IDLE;
    run_random(30, 85, 5, -1);
    // drain toward empty
    idle_phase = PH_RECV_STALL;
    run_random(25, 5, 85, -1);
    idle_phase = PH_BOTH;
    run_random(25, 5, 85, -1);
    // mixed traffic
    idle_phase = PH_STEADY;
    run_random(18, 45, 35, -1);
    idle_phase = PH_BOTH;
    run_random(18, 45, 35, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
